// File: sv/fxsg_pkg.sv
// Shared types and constants for the FIPS 186-2 SHA-1 generator.
`default_nettype none
package fxsg_pkg;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_GEN  = 1'b1;

    typedef struct packed {
        logic load;      // write key word
        logic start;     // init working vars, round counter to 0
        logic round;     // run one round
        logic finish;    // add IV into digest
        logic update;    // xkey = xkey + 1 + x, clear upper words
        logic shift_out; // advance output word
    } ctrl_t;

    typedef struct packed {
        logic last_round;
    } stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction
endpackage
`default_nettype wire

// File: sv/fxsg_datapath.sv
// Key store, message schedule window, SHA-1 round unit and xkey update.
`default_nettype none
module fxsg_datapath
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fxsg_pkg::ctrl_t ctrl,
    input  wire logic [3:0]     word_index,
    input  wire logic [31:0]    key_word,
    output fxsg_pkg::stat_t     stat,
    output logic [31:0]         out_word
);
    logic [31:0] key_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] x_reg [5];
    logic [6:0]  rnd_reg;
    logic [31:0] f, k, t, wnew;
    logic [159:0] sum;

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg); k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg; k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg); k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg; k = 32'hCA62C1D6;
        end
        t = fxsg_pkg::rotl(a_reg, 5) + f + e_reg + k + w_reg[0];
        wnew = fxsg_pkg::rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
        sum = {key_reg[0], key_reg[1], key_reg[2], key_reg[3], key_reg[4]}
            + {x_reg[0], x_reg[1], x_reg[2], x_reg[3], x_reg[4]} + 160'd1;
    end

    assign stat.last_round = (rnd_reg == 7'd79);
    assign out_word = x_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                key_reg[i] <= '0;
        end
        else if (ctrl.load)
            key_reg[word_index] <= key_word;
        else if (ctrl.update)
        begin
            for (int i = 0; i < 5; i++)
                key_reg[i] <= sum[159 - 32*i -: 32];
            for (int i = 5; i < 16; i++)
                key_reg[i] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_reg <= '0;
        else if (ctrl.start)
            rnd_reg <= '0;
        else if (ctrl.round)
            rnd_reg <= rnd_reg + 7'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= key_reg[i];
            a_reg <= fxsg_pkg::IV0; b_reg <= fxsg_pkg::IV1; c_reg <= fxsg_pkg::IV2;
            d_reg <= fxsg_pkg::IV3; e_reg <= fxsg_pkg::IV4;
        end
        else if (ctrl.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            e_reg <= d_reg; d_reg <= c_reg; c_reg <= fxsg_pkg::rotl(b_reg, 30);
            b_reg <= a_reg; a_reg <= t;
        end
        if (ctrl.finish)
        begin
            x_reg[0] <= fxsg_pkg::IV0 + a_reg; x_reg[1] <= fxsg_pkg::IV1 + b_reg;
            x_reg[2] <= fxsg_pkg::IV2 + c_reg; x_reg[3] <= fxsg_pkg::IV3 + d_reg;
            x_reg[4] <= fxsg_pkg::IV4 + e_reg;
        end
        else if (ctrl.shift_out)
        begin
            for (int i = 0; i < 4; i++)
                x_reg[i] <= x_reg[i+1];
            x_reg[4] <= x_reg[0];
        end
    end
endmodule
`default_nettype wire

// File: sv/fxsg_ctrl.sv
// Sequencer for load, compression rounds, digest output and xkey update.
`default_nettype none
module fxsg_ctrl
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        command,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,
    input  wire fxsg_pkg::stat_t stat,
    output fxsg_pkg::ctrl_t  ctrl
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic s_acc, m_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast = (cnt_reg == 3'd4);
    assign m_acc = m_tvalid && m_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && command == fxsg_pkg::CMD_LOAD)
                    ctrl.load = 1'b1;
                else if (s_acc)
                begin
                    ctrl.start = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                ctrl.round = 1'b1;
                if (stat.last_round)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                ctrl.finish = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                cnt_next = '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_acc)
                begin
                    ctrl.shift_out = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_tready) else $error("input taken while busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt_reg <= 3'd4) else $error("output count overrun");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |-> $past(stat.last_round)) else $error("early finish");
endmodule
`default_nettype wire

// File: sv/fips186_xkey_sha1_generator.sv
// Top level of the FIPS 186-2 SHA-1 based generator.
// A load word (command 0) writes one key word. A generate word
// (command 1) runs one SHA-1 compression of the key block in a single shared
// round unit: accept, 80 rounds, digest and xkey update, then five output
// words, h0 first, the fifth with tlast. One item is in work at a time.
`default_nettype none
module fips186_xkey_sha1_generator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // word_index[3:0], key_word[35:4], zero fill
    input  wire logic        s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // random_word
    output logic             m_tlast
);
    fxsg_pkg::ctrl_t ctrl;
    fxsg_pkg::stat_t stat;

    fxsg_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .command(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tlast(m_tlast), .stat(stat), .ctrl(ctrl)
    );

    fxsg_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .word_index(s_tdata[3:0]),
        .key_word(s_tdata[35:4]), .stat(stat), .out_word(m_tdata)
    );
endmodule
`default_nettype wire

// File: test/tb_fips186_xkey_sha1_generator.sv
// Self-checking testbench for the FIPS 186-2 SHA-1 based generator.
`default_nettype none
module tb_fips186_xkey_sha1_generator;

    typedef struct packed {
        logic        command;
        logic [3:0]  word_index;
        logic [31:0] key_word;
        logic [2:0]  gap;
        logic        drain;
    } req_t;

    typedef struct packed {
        logic [31:0] random_word;
        logic        last;
    } rnd_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    req_t        pending_q[$];
    rnd_t        expected_q[$];
    logic [31:0] xkey[16];
    int          error_count = 0;
    int          cycle_count = 0;
    int          gen_sent;
    int          send_wait;
    int          recv_wait;
    int          recv_draw;
    bit          draining;

    fips186_xkey_sha1_generator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [31:0] rol32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Compute x from the key block, queue its five words, advance xkey.
    task automatic predict_generate();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        logic [31:0] x[5];
        logic [32:0] sum;
        logic        carry;
        rnd_t        r;
        for (int i = 0; i < 16; i++)
            w[i] = xkey[i];
        for (int i = 16; i < 80; i++)
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = fxsg_pkg::IV0; b = fxsg_pkg::IV1; c = fxsg_pkg::IV2;
        d = fxsg_pkg::IV3; e = fxsg_pkg::IV4;
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        x[0] = fxsg_pkg::IV0 + a; x[1] = fxsg_pkg::IV1 + b; x[2] = fxsg_pkg::IV2 + c;
        x[3] = fxsg_pkg::IV3 + d; x[4] = fxsg_pkg::IV4 + e;
        for (int i = 0; i < 5; i++)
        begin
            r.random_word = x[i];
            r.last = (i == 4);
            expected_q.push_back(r);
        end
        carry = 1'b1;
        for (int i = 4; i >= 0; i--)
        begin
            sum = {1'b0, xkey[i]} + {1'b0, x[i]} + carry;
            xkey[i] = sum[31:0];
            carry = sum[32];
        end
        for (int i = 5; i < 16; i++)
            xkey[i] = '0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic req_t make_req(logic cmd, logic [3:0] idx, logic [31:0] kw);
        req_t q;
        q.command = cmd;
        q.word_index = idx;
        q.key_word = kw;
        q.gap = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(0, 6));
        q.drain = 1'b0;
        return q;
    endfunction

    // Driver: hold each word until accepted, then wait its gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= fxsg_pkg::CMD_LOAD;
            send_wait <= 0;
            draining <= 1'b0;
            gen_sent = 0;
            for (int i = 0; i < 16; i++)
                xkey[i] = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == fxsg_pkg::CMD_GEN)
                begin
                    predict_generate();
                    gen_sent++;
                end
                else
                    xkey[s_tdata[3:0]] = s_tdata[35:4];
            end
            if (!s_tvalid || s_tready)
            begin
                if (draining && expected_q.size() != 0)
                    s_tvalid <= 1'b0;
                else if (send_wait > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_wait <= send_wait - 1;
                    draining <= 1'b0;
                end
                else if (pending_q.size() != 0 && !(pending_q[0].drain && !draining))
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_q[0].command;
                    s_tdata  <= {4'b0, pending_q[0].key_word, pending_q[0].word_index};
                    send_wait <= pending_q[0].gap;
                    draining <= 1'b0;
                    void'(pending_q.pop_front());
                end
                else if (pending_q.size() != 0)
                begin
                    s_tvalid <= 1'b0;
                    draining <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls on the result side, compare each word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("unexpected word", m_tdata, 32'h0);
                end
                else
                begin
                    if (m_tdata !== expected_q[0].random_word)
                        report_mismatch("random_word", m_tdata, expected_q[0].random_word);
                    if (m_tlast !== expected_q[0].last)
                        report_mismatch("last", 32'(m_tlast), 32'(expected_q[0].last));
                    void'(expected_q.pop_front());
                end
                recv_draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                recv_wait <= recv_draw;
                m_tready <= (recv_draw == 0);
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                m_tready <= (recv_wait == 1);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        req_t q;
        logic [31:0] v;
        rst_n = 1'b0;
        // Directed: generate from an all-zero block, extremes of every field.
        pending_q.push_back(make_req(fxsg_pkg::CMD_GEN, 4'd0, 32'h0));
        for (int i = 0; i < 16; i++)
            pending_q.push_back(make_req(fxsg_pkg::CMD_LOAD, 4'(i),
                                         (i % 2) ? 32'hFFFFFFFF : 32'h00000000));
        pending_q.push_back(make_req(fxsg_pkg::CMD_GEN, 4'hF, 32'hFFFFFFFF));
        // All-ones low key: forces a carry out of the 160-bit add.
        for (int i = 0; i < 5; i++)
            pending_q.push_back(make_req(fxsg_pkg::CMD_LOAD, 4'(i), 32'hFFFFFFFF));
        q = make_req(fxsg_pkg::CMD_GEN, 4'h0, 32'h0);
        q.drain = 1'b1;
        pending_q.push_back(q);
        // Random: a mix of full key loads, single key word loads and generates, some back to back generates.
        while (pending_q.size() < 230)
        begin
            case ($urandom_range(0, 3))
                0: for (int i = 0; i < 16; i++)
                       pending_q.push_back(make_req(fxsg_pkg::CMD_LOAD, 4'(i), $urandom));
                1: pending_q.push_back(make_req(fxsg_pkg::CMD_LOAD,
                                                4'($urandom_range(0, 15)), $urandom));
                default:
                begin
                    v = $urandom;
                    q = make_req(fxsg_pkg::CMD_GEN, v[3:0], $urandom);
                    q.drain = ($urandom_range(0, 15) == 0);
                    pending_q.push_back(q);
                end
            endcase
        end
        pending_q.push_back(make_req(fxsg_pkg::CMD_GEN, 4'h0, 32'h0));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while ((pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
               && cycle_count < 400000)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (cycle_count >= 400000)
            $display("Testbench completed WITH ERRORS");
        else if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
